// File: hw/rtl/ljg_pkg.sv
// ----------------------------------------------------------------------------
// ljg_pkg
// Shared types, constants and command codes of the pair energy core.
// ----------------------------------------------------------------------------
package ljg_pkg;

  localparam int unsigned MaxParticlesDefault = 256;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned EnergyW = 48;
  localparam int unsigned AccW    = 64;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_ONE   = 2'd1,
    CMD_TOTAL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_COUNT   = 2'd0,
    REG_GRAVITY = 2'd1,
    REG_CUTOFF  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  localparam logic [63:0] AccCap    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] AccCapNeg = 64'hC000_0000_0000_0000;
  localparam logic [47:0] EMax      = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] EMin      = 48'h8000_0000_0000;
  localparam logic [31:0] NearLimit = 32'd2048;

  // clip a sum to +/- 2^62
  function automatic logic [63:0] clip_acc(input logic [64:0] s);
    logic signed [64:0] v;
    v = signed'(s);
    if (v > signed'({1'b0, AccCap}))         return AccCap;
    else if (v < signed'({1'b1, AccCapNeg})) return AccCapNeg;
    else                                    return s[63:0];
  endfunction

endpackage

// File: hw/rtl/ljg_div.sv
// ----------------------------------------------------------------------------
// ljg_div
// Radix-2 restoring divider, 2^40 / d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ljg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] den,
  output logic        done,
  output logic [40:0] quo
);

  logic [41:0] num;
  logic [32:0] rem;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem, num[41]} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= 42'h1 << 40;
        rem  <= '0;
        d    <= den;
        cnt  <= 6'd42;
      end else if (busy) begin
        num <= {num[40:0], ~trial[33]};
        rem <= trial[33] ? {rem[31:0], num[41]} : trial[32:0];
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = num[40:0];

endmodule

// File: hw/rtl/lennard_jones_gravity_energy_core.sv
// ----------------------------------------------------------------------------
// lennard_jones_gravity_energy_core
// Truncated Lennard-Jones plus gravity energy over a stored particle set.
//
// channel  dir  fields
// s_axis   in   tdata: cmd, particle_index, pos_x, pos_y, pos_z
// m_axis   out  tdata: energy, saturated
// cfg      in   wr_en / wr_index / wr_data
//
// a write is stored when it is accepted. a query runs an accept step, gravity
// steps, skipped self pairs, pairs tested against the cutoff and counted pairs
// (the 42-step divider, then three 64x32 products on the shared 32x32 multiplier),
// an outer step per particle and the output handshake;
// a total query walks n(n-1)/2 pairs plus n gravity steps.
// synchronous reset clears control; position memory is undefined until written.
// input is not ready while a query runs or a result waits.
// ----------------------------------------------------------------------------
module lennard_jones_gravity_energy_core #(
  parameter int unsigned MAX_PARTICLES = ljg_pkg::MaxParticlesDefault,
  localparam int unsigned IdxW = $clog2(MAX_PARTICLES)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // cmd, particle_index, pos_x, pos_y, pos_z, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,  // energy, saturated, pad
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [31:0]  wr_data
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_GRAV  = 13'b0000000000100,
    S_GRAV2 = 13'b0000000001000,
    S_PAIR  = 13'b0000000010000,
    S_SQ    = 13'b0000000100000,
    S_TEST  = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_MUL   = 13'b0000100000000,
    S_MULW  = 13'b0001000000000,
    S_ADD   = 13'b0010000000000,
    S_NEXT  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  typedef logic [255:0][IdxW-1:0] kidx_tab_t;

  // index wrap onto the store size, built once from constants
  function automatic kidx_tab_t make_kidx_tab();
    kidx_tab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = IdxW'(i % MAX_PARTICLES);
    return tab;
  endfunction

  localparam kidx_tab_t KidxTab = make_kidx_tab();

  state_t state;
  logic [8:0]  particle_count;
  logic signed [31:0] gravity_factor;
  logic [31:0] cutoff_squared;
  logic [IdxW:0] n_act;
  logic [8:0] cnt_cfg;

  logic [71:0] mem [MAX_PARTICLES];
  logic [71:0] rd_a, rd_b;
  logic [IdxW-1:0] ia, ib;
  logic [IdxW:0]   ja, jb;
  logic total;
  logic [63:0] acc;
  logic ok;
  logic [47:0] energy;
  logic sat;

  logic [1:0]  cmd;
  logic [7:0]  pidx;
  logic [IdxW-1:0] kidx;
  assign cmd  = s_axis_tdata[1:0];
  assign pidx = s_axis_tdata[9:2];
  assign kidx = KidxTab[pidx];

  // shared multiplier 64 x 32 split into two 32x32 halves
  logic [63:0] m_a;
  logic [31:0] m_b;
  logic        m_hi;
  logic [63:0] m_p;
  logic [95:0] m_res;
  logic [1:0]  dim;
  logic [1:0]  mstep;
  logic [63:0] r2;
  logic [40:0] inv;
  logic [63:0] c, t;
  logic        div_start, div_done;
  logic [40:0] div_q;

  assign m_p = (m_hi ? m_a[63:32] : m_a[31:0]) * m_b;

  ljg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .den(r2[47:16]),
    .done(div_done), .quo(div_q)
  );

  assign n_act = (32'(cnt_cfg) > MAX_PARTICLES) ? (IdxW+1)'(MAX_PARTICLES)
                                                 : (IdxW+1)'(cnt_cfg);
  assign cnt_cfg = particle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= 9'd256;
      gravity_factor <= '0;
      cutoff_squared <= 32'd589824;
    end else if (wr_en) begin
      unique case (ljg_pkg::reg_idx_t'(wr_index))
        ljg_pkg::REG_COUNT:   particle_count <= wr_data[8:0];
        ljg_pkg::REG_GRAVITY: gravity_factor <= signed'(wr_data);
        ljg_pkg::REG_CUTOFF:  cutoff_squared <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready && cmd == ljg_pkg::CMD_WRITE)
      mem[kidx] <= s_axis_tdata[81:10];
    rd_a <= mem[ia];
    rd_b <= mem[ib];
  end

  // per-dimension difference magnitude
  logic [23:0] ca, cb, dmag;
  always_comb begin
    unique case (dim)
      2'd0:    begin ca = rd_a[23:0];  cb = rd_b[23:0];  end
      2'd1:    begin ca = rd_a[47:24]; cb = rd_b[47:24]; end
      default: begin ca = rd_a[71:48]; cb = rd_b[71:48]; end
    endcase
    dmag = (ca >= cb) ? ca - cb : cb - ca;
  end

  logic [63:0] gterm;
  logic [64:0] gsum, psum;
  logic signed [63:0] gprod;
  logic signed [63:0] term;
  assign gprod = signed'(m_res[63:0]);
  always_comb begin
    if (!gprod[63]) gterm = {16'd0, gprod[63:16]};
    else gterm = -( (64'(-gprod) + 64'd65535) >> 16);
    term = 64'(signed'({t[61:0], 2'b0})) - 64'(signed'({c[61:0], 2'b0}));
    gsum = {acc[63], acc} + {gterm[63], gterm};
    psum = {acc[63], acc} + {term[63], term};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_start <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          if (cmd == ljg_pkg::CMD_ONE || cmd == ljg_pkg::CMD_TOTAL) begin
            total <= (cmd == ljg_pkg::CMD_TOTAL);
            ia <= (cmd == ljg_pkg::CMD_TOTAL) ? '0 : kidx;
            ja <= '0;
            jb <= (cmd == ljg_pkg::CMD_TOTAL) ? (IdxW+1)'(1) : '0;
            ib <= (cmd == ljg_pkg::CMD_TOTAL) ? IdxW'(1) : '0;
            acc <= '0;
            ok <= 1'b1;
            mstep <= 2'd3;
            state <= S_RD;
          end
        end
        // after a read decide gravity vs pair
        S_RD: begin
          if (mstep == 2'd3) state <= S_GRAV;
          else state <= S_PAIR;
        end
        S_GRAV: begin
          if (total && ja >= n_act) state <= S_OUT;
          else begin
            m_a <= {{32{gravity_factor[31]}}, gravity_factor};
            m_b <= {8'd0, rd_a[71:48]};
            state <= S_GRAV2;
          end
        end
        S_GRAV2: begin
          // gravity: only low half matters (signed x unsigned 24 fits)
          m_res <= {32'd0, 64'(signed'(gravity_factor) * signed'({8'd0, rd_a[71:48]}))};
          state <= S_ADD;
          mstep <= 2'd3;
        end
        S_PAIR: begin
          if (jb >= n_act) state <= S_NEXT;
          else if (!total && jb[IdxW-1:0] == ia && jb < (IdxW+1)'(MAX_PARTICLES)) begin
            jb <= jb + 1'b1;
            ib <= IdxW'(jb + 1'b1);
            state <= S_RD;
            mstep <= 2'd2;
          end else begin
            dim <= 2'd0;
            r2 <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          r2 <= r2 + {16'd0, 48'(dmag) * 48'(dmag)};
          if (dim == 2'd2) state <= S_TEST;
          else dim <= dim + 2'd1;
        end
        S_TEST: begin
          if (r2 > {16'd0, cutoff_squared, 16'd0}) begin
            jb <= jb + 1'b1;
            ib <= IdxW'(jb + 1'b1);
            mstep <= 2'd2;
            state <= S_RD;
          end else if (r2[63:16] < 48'(ljg_pkg::NearLimit)) begin
            ok <= 1'b0;
            state <= S_OUT;
          end else begin
            div_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          inv <= div_q;
          m_a <= {23'd0, div_q};
          m_b <= div_q[31:0];
          m_hi <= 1'b0;
          mstep <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          // step0: inv*inv; step1: s2*inv; step2: c*c
          m_res <= {32'd0, m_p};
          m_hi <= 1'b1;
          state <= S_MULW;
        end
        S_MULW: begin
          logic [95:0] full;
          full = {m_p, 32'd0} + m_res;
          m_hi <= 1'b0;
          unique case (mstep)
            2'd0: begin
              m_a <= {16'd0, full[71:24]};
              m_b <= inv[31:0];
              mstep <= 2'd1;
              state <= S_MUL;
            end
            2'd1: begin
              c <= {32'd0, full[63:32]};
              m_a <= {32'd0, full[63:32]};
              m_b <= full[63:32];
              mstep <= 2'd2;
              state <= S_MUL;
            end
            default: begin
              t <= {16'd0, full[63:16]};
              mstep <= 2'd2;
              state <= S_ADD;
            end
          endcase
        end
        S_ADD: begin
          if (mstep == 2'd3) begin
            acc <= ljg_pkg::clip_acc(gsum);
            if (total) begin
              jb <= ja + 1'b1;
              ib <= IdxW'(ja + 1'b1);
              state <= S_RD;
              mstep <= 2'd2;
            end else begin
              jb <= '0; ib <= '0; state <= S_RD; mstep <= 2'd2;
            end
          end else begin
            acc <= ljg_pkg::clip_acc(psum);
            jb <= jb + 1'b1;
            ib <= IdxW'(jb + 1'b1);
            state <= S_RD;
          end
        end
        S_NEXT: begin
          if (!total) state <= S_OUT;
          else begin
            ja <= ja + 1'b1;
            ia <= IdxW'(ja + 1'b1);
            mstep <= 2'd3;
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            if (!ok) begin energy <= ljg_pkg::EMax; sat <= 1'b1; end
            else if (signed'(acc) > 64'(signed'(ljg_pkg::EMax))) begin
              energy <= ljg_pkg::EMax; sat <= 1'b1;
            end else if (signed'(acc) < 64'(signed'(ljg_pkg::EMin))) begin
              energy <= ljg_pkg::EMin; sat <= 1'b1;
            end else begin energy <= acc[47:0]; sat <= 1'b0; end
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {7'd0, sat, energy};

  a_out_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result outside output state");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result waits");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid) else $error("result repeated");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams position writes, one-particle and total energy queries into the
// pair energy core, predicts each energy and saturation flag, and checks the
// results in order under several configurations and handshake pressure.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NPart = 256;
  localparam longint Cap = 64'sh4000_0000_0000_0000;
  localparam longint EHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ELo = -64'sh0000_8000_0000_0000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // cmd, particle_index, pos_x, pos_y, pos_z, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // energy, saturated, pad
  logic        wr_en;
  ljg_pkg::reg_idx_t wr_index;
  logic [31:0] wr_data;

  lennard_jones_gravity_energy_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // shadow of the particle store and registers
  logic [23:0]        px [NPart];
  logic [23:0]        py [NPart];
  logic [23:0]        pz [NPart];
  logic [8:0]         count_reg;
  logic signed [31:0] gravity_reg;
  logic [31:0]        cutoff_reg;

  logic [48:0] energy_q[$];   // {saturated, energy}
  int errors;
  int n_writes, n_queries, n_results;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[lennard_jones_gravity_energy_core] ERROR");
    $finish;
  end

  function automatic longint clip_sum(longint s);
    if (s > Cap) return Cap;
    if (s < -Cap) return -Cap;
    return s;
  endfunction

  // adds the pair term of a and b; returns 0 when the pair is too close
  function automatic bit add_pair_term(int a, int b, inout longint acc);
    logic [63:0] r2, dq, inv, s2, c, t;
    longint d;
    r2 = 0;
    d = longint'(px[a]) - longint'(px[b]); if (d < 0) d = -d; r2 += d * d;
    d = longint'(py[a]) - longint'(py[b]); if (d < 0) d = -d; r2 += d * d;
    d = longint'(pz[a]) - longint'(pz[b]); if (d < 0) d = -d; r2 += d * d;
    if (r2 > ({32'd0, cutoff_reg} << 16)) return 1'b1;
    dq = r2 >> 16;
    if (dq < 64'd2048) return 1'b0;
    inv = (64'd1 << 40) / dq;
    s2 = (inv * inv) >> 24;
    c = ((s2 * inv) >> 24) >> 8;
    t = (c * c) >> 16;
    acc = clip_sum(acc + 4 * (longint'(t) - longint'(c)));
    return 1'b1;
  endfunction

  function automatic longint gravity_term(int i);
    longint p;
    p = longint'(gravity_reg) * longint'({40'd0, pz[i]});
    return p >>> 16;
  endfunction

  function automatic logic [48:0] predict_energy(ljg_pkg::cmd_t cmd, int k);
    longint acc;
    bit ok;
    int n;
    acc = 0;
    ok = 1'b1;
    n = (count_reg > NPart) ? NPart : int'(count_reg);
    if (cmd == ljg_pkg::CMD_ONE) begin
      acc = clip_sum(acc + gravity_term(k));
      for (int i = 0; i < n && ok; i++)
        if (i != k) ok = add_pair_term(k, i, acc);
    end else begin
      for (int i = 0; i < n && ok; i++) begin
        acc = clip_sum(acc + gravity_term(i));
        for (int j = i + 1; j < n && ok; j++) ok = add_pair_term(i, j, acc);
      end
    end
    if (!ok) return {1'b1, EHi[47:0]};
    if (acc > EHi) return {1'b1, EHi[47:0]};
    if (acc < ELo) return {1'b1, ELo[47:0]};
    return {1'b0, acc[47:0]};
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (energy_q.size() == 0) begin
        $error("unexpected result energy=%h", m_axis_tdata[47:0]);
        errors++;
      end else begin
        logic [48:0] exp_r;
        exp_r = energy_q.pop_front();
        if (m_axis_tdata[47:0] !== exp_r[47:0]) begin
          $error("energy: expected %h, got %h", exp_r[47:0], m_axis_tdata[47:0]);
          errors++;
        end
        if (m_axis_tdata[48] !== exp_r[48]) begin
          $error("saturated: expected %b, got %b", exp_r[48], m_axis_tdata[48]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_item(ljg_pkg::cmd_t cmd, int idx, logic [23:0] x, logic [23:0] y,
                           logic [23:0] z);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, z, y, x, idx[7:0], cmd};
    do @(posedge clk); while (!s_axis_tready);
    case (cmd)
      ljg_pkg::CMD_WRITE: begin
        px[idx] = x; py[idx] = y; pz[idx] = z;
        n_writes++;
      end
      ljg_pkg::CMD_ONE, ljg_pkg::CMD_TOTAL: begin
        energy_q.push_back(predict_energy(cmd, idx));
        n_queries++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
    // a write may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(ljg_pkg::reg_idx_t r, logic [31:0] v);
    @(negedge clk);
    wr_en = 1'b1; wr_index = r; wr_data = v;
    @(negedge clk);
    wr_en = 1'b0;
    case (r)
      ljg_pkg::REG_COUNT:   count_reg = v[8:0];
      ljg_pkg::REG_GRAVITY: gravity_reg = v;
      ljg_pkg::REG_CUTOFF:  cutoff_reg = v;
      default: ;
    endcase
  endtask

  // mostly clustered so that pairs fall inside the cutoff
  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'h400000 + 24'($urandom_range(0, 24'h30000));
  endfunction

  task automatic test_fill_store();
    for (int i = 0; i < NPart; i++)
      send_item(ljg_pkg::CMD_WRITE, i, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic test_directed();
    wait_idle();
    write_reg(ljg_pkg::REG_COUNT, 32'd2);
    write_reg(ljg_pkg::REG_GRAVITY, 32'h7FFF_FFFF);
    write_reg(ljg_pkg::REG_CUTOFF, 32'hFFFF_FFFF);
    send_item(ljg_pkg::CMD_WRITE, 0, 24'h000000, 24'h000000, 24'hFFFFFF);
    send_item(ljg_pkg::CMD_WRITE, 1, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    send_item(ljg_pkg::CMD_ONE, 0, 0, 0, 0);
    send_item(ljg_pkg::CMD_TOTAL, 0, 0, 0, 0);
    // hold off until the queue drains
    wait_idle();
    write_reg(ljg_pkg::REG_GRAVITY, 32'h8000_0000);
    write_reg(ljg_pkg::REG_CUTOFF, 32'd0);
    send_item(ljg_pkg::CMD_ONE, 1, 0, 0, 0);
    send_item(ljg_pkg::CMD_TOTAL, 0, 0, 0, 0);
    send_item(ljg_pkg::CMD_NONE, 3, 24'h123456, 0, 0);
    // pair at zero distance and one still inside the near limit
    send_item(ljg_pkg::CMD_WRITE, 1, 24'h000000, 24'h000000, 24'hFFFFFF);
    send_item(ljg_pkg::CMD_ONE, 1, 0, 0, 0);
    wait_idle();
    write_reg(ljg_pkg::REG_CUTOFF, 32'hFFFF_FFFF);
    send_item(ljg_pkg::CMD_ONE, 1, 0, 0, 0);
    send_item(ljg_pkg::CMD_WRITE, 1, 24'h002000, 24'h000000, 24'hFFFFFF);
    send_item(ljg_pkg::CMD_TOTAL, 0, 0, 0, 0);
    send_item(ljg_pkg::CMD_ONE, 200, 0, 0, 0);
    wait_idle();
    // counts zero and one, then a count beyond the store size
    write_reg(ljg_pkg::REG_COUNT, 32'd0);
    send_item(ljg_pkg::CMD_ONE, 5, 0, 0, 0);
    send_item(ljg_pkg::CMD_TOTAL, 0, 0, 0, 0);
    wait_idle();
    write_reg(ljg_pkg::REG_COUNT, 32'd1);
    send_item(ljg_pkg::CMD_ONE, 0, 0, 0, 0);
    send_item(ljg_pkg::CMD_TOTAL, 0, 0, 0, 0);
    wait_idle();
    write_reg(ljg_pkg::REG_COUNT, 32'd511);
    write_reg(ljg_pkg::REG_CUTOFF, 32'd589824);
    send_item(ljg_pkg::CMD_ONE, 255, 0, 0, 0);
    wait_idle();
    write_reg(ljg_pkg::REG_COUNT, 32'd256);
    send_item(ljg_pkg::CMD_ONE, 128, 0, 0, 0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int items);
    int r, idx, n;
    wait_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(ljg_pkg::REG_COUNT, 32'($urandom_range(2, 12)));
    write_reg(ljg_pkg::REG_GRAVITY, $urandom);
    case ($urandom_range(0, 3))
      0: write_reg(ljg_pkg::REG_CUTOFF, 32'd589824);
      1: write_reg(ljg_pkg::REG_CUTOFF, 32'hFFFF_FFFF);
      2: write_reg(ljg_pkg::REG_CUTOFF, 32'd0);
      default: write_reg(ljg_pkg::REG_CUTOFF, 32'($urandom_range(0, 32'h0010_0000)));
    endcase
    n = count_reg;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
      if (r < 45) begin
        send_item(ljg_pkg::CMD_WRITE, idx, rand_coord(), rand_coord(), rand_coord());
      end else if (r < 75) begin
        send_item(ljg_pkg::CMD_ONE, idx, 24'($urandom), 24'($urandom), 24'($urandom));
      end else if (r < 92) begin
        send_item(ljg_pkg::CMD_TOTAL, idx, 24'($urandom), 0, 0);
      end else begin
        send_item(ljg_pkg::CMD_NONE, idx, 24'($urandom), 24'($urandom), 24'($urandom));
        i--;
      end
    end
  endtask

  initial begin
    errors = 0; n_writes = 0; n_queries = 0; n_results = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    count_reg = 9'd256; gravity_reg = 0; cutoff_reg = 32'd589824;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    wr_en = 1'b0; wr_index = ljg_pkg::REG_COUNT; wr_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_store();
    test_directed();
    test_random_phase(0, 0, 110);
    test_random_phase(88, 0, 110);
    test_random_phase(0, 88, 110);
    test_random_phase(33, 33, 110);
    test_random_phase(0, 0, 110);
    test_random_phase(88, 0, 110);
    test_random_phase(0, 88, 110);
    test_random_phase(33, 33, 110);
    wait_idle();
    repeat (100) @(posedge clk);

    $display("covered %0d position writes and %0d energy queries, %0d results checked",
             n_writes, n_queries, n_results);
    $display("under 8 random configurations plus directed extremes and close pairs");
    if (errors == 0 && energy_q.size() == 0) begin
      $display("[lennard_jones_gravity_energy_core] OK");
    end else begin
      $display("[lennard_jones_gravity_energy_core] ERROR");
    end
    $finish;
  end

endmodule
